>>> hdl/mlprq_pkg.sv
// Shared types, sizes and helpers of the multilevel priority ready queue.
package mlprq_pkg;

   localparam int NUM_LEVELS    = 4;
   localparam int LEVEL_DEPTH   = 16;
   localparam int ID_BITS       = 8;

   localparam int LEVEL_BITS    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PTR_BITS      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_BITS      = $clog2(LEVEL_DEPTH + 1);
   localparam int SLOT_COUNT    = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_BITS     = $clog2(SLOT_COUNT);

   localparam int OP_BITS       = 1;
   localparam int PROC_ID_BITS  = 8;
   localparam int PRIO_BITS     = 3;
   localparam int STATUS_BITS   = 2;
   localparam int QUANTUM_BITS  = 16;

   localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET = 16'd10;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_PRIO   = 2'd1,
      STATUS_NONE_READY = 2'd2,
      STATUS_LEVEL_FULL = 2'd3
   } status_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_SCHEDULE = 1'b0,
      OP_DISPATCH = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] n;
      if (p == PTR_BITS'(LEVEL_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [LEVEL_BITS-1:0] lvl,
                                                      input logic [PTR_BITS-1:0] p);
      return ADDR_BITS'(lvl) * ADDR_BITS'(LEVEL_DEPTH) + ADDR_BITS'(p);
   endfunction

endpackage

>>> hdl/mlprq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mlprq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/multilevel_priority_ready_queue.sv
// Top level of the strict-priority multilevel FIFO ready queue.
// A schedule or a failed dispatch gives its result in the cycle after acceptance;
// a successful dispatch gives it after the store read state; no request is taken then.
// Throughput: one schedule per cycle while the result output is not stalled.
// Reset (synchronous): all levels empty, quantum 10; store contents stay undefined.
// No clearing pass: an item may be accepted in the first cycle after reset.
module multilevel_priority_ready_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [mlprq_pkg::OP_BITS-1:0]          req_op,
   input  logic [mlprq_pkg::PROC_ID_BITS-1:0]     req_proc_id,
   input  logic [mlprq_pkg::PRIO_BITS-1:0]        req_prio_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [mlprq_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic                                   rsp_dispatched,
   output logic [mlprq_pkg::PROC_ID_BITS-1:0]     rsp_running_id,
   output logic [mlprq_pkg::QUANTUM_BITS-1:0]     rsp_ticks_loaded,
   input  logic                                   csr_wr_en,
   input  logic [mlprq_pkg::QUANTUM_BITS-1:0]     csr_wr_data
);

   localparam int NL = mlprq_pkg::NUM_LEVELS;

   mlprq_pkg::state_type                     state_ff, state_in;
   logic [mlprq_pkg::PTR_BITS-1:0]           head_ff [NL];
   logic [mlprq_pkg::PTR_BITS-1:0]           head_in [NL];
   logic [mlprq_pkg::PTR_BITS-1:0]           tail_ff [NL];
   logic [mlprq_pkg::PTR_BITS-1:0]           tail_in [NL];
   logic [mlprq_pkg::CNT_BITS-1:0]           count_ff [NL];
   logic [mlprq_pkg::CNT_BITS-1:0]           count_in [NL];
   logic [mlprq_pkg::QUANTUM_BITS-1:0]       quantum_ff;

   logic                                     rsp_valid_ff, rsp_valid_in;
   mlprq_pkg::status_type                    rsp_status_ff, rsp_status_in;
   logic                                     rsp_dispatched_ff, rsp_dispatched_in;
   logic [mlprq_pkg::PROC_ID_BITS-1:0]       rsp_running_id_ff, rsp_running_id_in;
   logic [mlprq_pkg::QUANTUM_BITS-1:0]       rsp_ticks_ff, rsp_ticks_in;

   logic                                     out_free;
   logic                                     take;
   logic                                     prio_bad;
   logic [mlprq_pkg::LEVEL_BITS-1:0]         lvl;
   logic                                     any_ready;
   logic [mlprq_pkg::LEVEL_BITS-1:0]         sel;

   logic                                     ram_wr_en;
   logic [mlprq_pkg::ADDR_BITS-1:0]          ram_wr_addr;
   logic [mlprq_pkg::ID_BITS-1:0]            ram_wr_data;
   logic                                     ram_rd_en;
   logic [mlprq_pkg::ADDR_BITS-1:0]          ram_rd_addr;
   logic [mlprq_pkg::ID_BITS-1:0]            ram_rd_data;

   mlprq_ram #(
      .WIDTH (mlprq_pkg::ID_BITS),
      .DEPTH (mlprq_pkg::SLOT_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == mlprq_pkg::ST_IDLE) && out_free);
   assign take      = req_valid && !req_stall;
   assign prio_bad  = 32'(req_prio_level) >= 32'(mlprq_pkg::NUM_LEVELS);
   assign lvl       = req_prio_level[mlprq_pkg::LEVEL_BITS-1:0];

   always_comb begin
      any_ready = 1'b0;
      sel       = '0;
      for (int i = NL - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            any_ready = 1'b1;
            sel       = mlprq_pkg::LEVEL_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_dispatched_in = rsp_dispatched_ff;
      rsp_running_id_in = rsp_running_id_ff;
      rsp_ticks_in      = rsp_ticks_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = mlprq_pkg::slot_addr(lvl, tail_ff[lvl]);
      ram_wr_data       = mlprq_pkg::ID_BITS'(req_proc_id);
      ram_rd_en         = 1'b0;
      ram_rd_addr       = mlprq_pkg::slot_addr(sel, head_ff[sel]);

      case (state_ff)
         mlprq_pkg::ST_IDLE: begin
            if (take) begin
               rsp_dispatched_in = 1'b0;
               rsp_running_id_in = '0;
               rsp_ticks_in      = '0;
               if (req_op == mlprq_pkg::OP_SCHEDULE) begin
                  rsp_valid_in = 1'b1;
                  if (prio_bad) begin
                     rsp_status_in = mlprq_pkg::STATUS_BAD_PRIO;
                  end else if (count_ff[lvl] == mlprq_pkg::CNT_BITS'(mlprq_pkg::LEVEL_DEPTH)) begin
                     rsp_status_in = mlprq_pkg::STATUS_LEVEL_FULL;
                  end else begin
                     rsp_status_in  = mlprq_pkg::STATUS_OK;
                     ram_wr_en      = 1'b1;
                     tail_in[lvl]   = mlprq_pkg::ptr_next(tail_ff[lvl]);
                     count_in[lvl]  = count_ff[lvl] + 1'b1;
                  end
               end else if (!any_ready) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mlprq_pkg::STATUS_NONE_READY;
               end else begin
                  ram_rd_en     = 1'b1;
                  head_in[sel]  = mlprq_pkg::ptr_next(head_ff[sel]);
                  count_in[sel] = count_ff[sel] - 1'b1;
                  state_in      = mlprq_pkg::ST_READ;
               end
            end
         end
         mlprq_pkg::ST_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = mlprq_pkg::STATUS_OK;
            rsp_dispatched_in = 1'b1;
            rsp_running_id_in = mlprq_pkg::PROC_ID_BITS'(ram_rd_data);
            rsp_ticks_in      = quantum_ff;
            state_in          = mlprq_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlprq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlprq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         quantum_ff   <= mlprq_pkg::QUANTUM_RESET;
         for (int i = 0; i < NL; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff     <= rsp_status_in;
      rsp_dispatched_ff <= rsp_dispatched_in;
      rsp_running_id_ff <= rsp_running_id_in;
      rsp_ticks_ff      <= rsp_ticks_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_dispatched   = rsp_dispatched_ff;
   assign rsp_running_id   = rsp_running_id_ff;
   assign rsp_ticks_loaded = rsp_ticks_ff;

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlprq_pkg::ST_READ |=> state_ff == mlprq_pkg::ST_IDLE)
      else $error("store read state held for more than one cycle");

   a_read_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlprq_pkg::ST_READ |-> !rsp_valid_ff)
      else $error("result register occupied while store read data returns");

   a_rd_then_load: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> state_ff == mlprq_pkg::ST_READ)
      else $error("store read issued without entering the read state");

   a_disp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dispatched_ff |-> rsp_status_ff == mlprq_pkg::STATUS_OK)
      else $error("dispatched item carries a failure status");

   a_no_wr_rd: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written and read by the same item");

endmodule
